### design/nearest_center_occupancy_counter_unit_macros.svh
// Assertion macros shared by the checker of the nearest center occupancy counter.
`ifndef NEAREST_CENTER_OCCUPANCY_COUNTER_UNIT_MACROS_SVH
`define NEAREST_CENTER_OCCUPANCY_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NCOC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NCOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/ncoc_pkg.sv
// Shared codes and types of the nearest center occupancy counter.
`default_nettype none

package ncoc_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_DETECT = 2'd1;
	localparam logic [1:0] ACT_FRAME  = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} scan_ctl_t;

endpackage

`default_nettype wire

### design/ncoc_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module ncoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/ncoc_nearest.sv
// Center store and pipelined squared-distance search for the nearest center.
`default_nettype none

module ncoc_nearest #(
	parameter int MAX_SPOTS = 256,
	parameter int COORD_BITS = 32,
	localparam int AW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         center_we,
	input  logic [AW-1:0]                center_waddr,
	input  logic [COORD_BITS-1:0]        center_wx,
	input  logic [COORD_BITS-1:0]        center_wy,
	input  logic [AW-1:0]                scan_addr,
	input  ncoc_pkg::scan_ctl_t          scan_ctl,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	output logic [AW-1:0]                best_idx,
	output logic                         done
);

	import ncoc_pkg::*;

	localparam int DW = 2 * COORD_BITS + 1;

	logic [2*COORD_BITS-1:0] center_rdata;
	logic signed [COORD_BITS-1:0] cx;
	logic signed [COORD_BITS-1:0] cy;
	logic [COORD_BITS:0] diff_x;
	logic [COORD_BITS:0] diff_y;
	logic [DW-1:0] dist_sum;

	scan_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;
	logic [2*COORD_BITS-1:0] sx_s3, sy_s3;
	logic [DW-1:0] best_dist_q;
	logic [AW-1:0] best_idx_q;
	logic done_q;

	ncoc_ram #(
		.WIDTH(2 * COORD_BITS),
		.DEPTH(MAX_SPOTS)
	) u_center_ram (
		.clk(clk),
		.we(center_we),
		.waddr(center_waddr),
		.wdata({center_wx, center_wy}),
		.raddr(scan_addr),
		.rdata(center_rdata)
	);

	assign cx = center_rdata[2*COORD_BITS-1:COORD_BITS];
	assign cy = center_rdata[COORD_BITS-1:0];

	// The magnitude of a difference of two signed values always fits in COORD_BITS.
	assign diff_x = (cx >= pos_x) ? ({cx[COORD_BITS-1], cx} - {pos_x[COORD_BITS-1], pos_x})
		: ({pos_x[COORD_BITS-1], pos_x} - {cx[COORD_BITS-1], cx});
	assign diff_y = (cy >= pos_y) ? ({cy[COORD_BITS-1], cy} - {pos_y[COORD_BITS-1], pos_y})
		: ({pos_y[COORD_BITS-1], pos_y} - {cy[COORD_BITS-1], cy});

	assign dist_sum = {1'b0, sx_s3} + {1'b0, sy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= scan_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			done_q <= ctl_s3.valid && ctl_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_addr;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		dx_s2 <= diff_x[COORD_BITS-1:0];
		dy_s2 <= diff_y[COORD_BITS-1:0];
		sx_s3 <= dx_s2 * dx_s2;
		sy_s3 <= dy_s2 * dy_s2;
		// Strictly smaller replaces, so the lowest index wins a tie.
		if (ctl_s3.valid && (ctl_s3.first || (dist_sum < best_dist_q))) begin
			best_dist_q <= dist_sum;
			best_idx_q <= idx_s3;
		end
	end

	assign best_idx = best_idx_q;
	assign done = done_q;

endmodule

`default_nettype wire

### design/nearest_center_occupancy_counter_unit.sv
// Top level of the nearest center occupancy counter: control, count store and result register.
//
// Items arrive on the item channel (item_valid, item_stall) and each one yields exactly
// one beat on the result channel (result_valid, result_stall). The block works on one
// item at a time and holds item_stall high until that item's result is in the result
// register; a result left waiting there does not keep the next item out.
// Path from accepted item to result beat, for n entries in use:
//   load center, read entry: one count entry read, then emit
//   bad index, detection with no entries: straight to emit
//   detection: n centers, one center per cycle through the distance pipeline, then drain
//   end of frame: all MAX_SPOTS entries, one count entry read-modify-write per cycle
// One read per cycle from each memory sets these rates.
// After reset the count memory is cleared in a pass over all MAX_SPOTS entries with item_stall
// high; the entries_in_use register is written through cfg_valid and cfg_ready at any
// time and reads zero after reset. When the receiver stalls, the result beat holds in
// its register and the block finishes the item in flight before it stalls the sender.
`default_nettype none

module nearest_center_occupancy_counter_unit #(
	parameter int MAX_SPOTS = 256,
	parameter int COORD_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  entries_in_use,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  entry_index,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [7:0]  hit_index,
	output logic [31:0] occupied_count,
	output logic [31:0] free_count
);

	import ncoc_pkg::*;

	localparam int AW = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
	localparam int NW = $clog2(MAX_SPOTS + 1);
	localparam int CW = 2 * COUNT_BITS + 1;

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_SCAN    = 8'b0000_0100,
		ST_DRAIN   = 8'b0000_1000,
		ST_CNT     = 8'b0001_0000,
		ST_EOF     = 8'b0010_0000,
		ST_EOF_END = 8'b0100_0000,
		ST_EMIT    = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [AW-1:0] scan_q;
	logic [8:0] entries_in_use_q;
	logic wb_valid_s1;
	logic [AW-1:0] wb_addr_s1;

	logic [1:0] action_q;
	logic [AW-1:0] cnt_addr_q;
	logic signed [COORD_BITS-1:0] px_q;
	logic signed [COORD_BITS-1:0] py_q;
	logic [1:0] res_status_q;
	logic [7:0] res_hit_q;
	logic [31:0] res_occ_q;
	logic [31:0] res_free_q;

	logic accept;
	logic range_ok;
	logic [AW-1:0] idx_addr;
	logic [NW-1:0] n_active;
	logic scan_last;
	logic walk_last;
	logic out_free;
	scan_ctl_t scan_ctl;
	logic [AW-1:0] best_idx;
	logic search_done;
	logic center_we;

	logic [AW-1:0] cnt_raddr;
	logic cnt_we;
	logic [AW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic [CW-1:0] cnt_rdata;
	logic cnt_seen;
	logic [COUNT_BITS-1:0] cnt_occ;
	logic [COUNT_BITS-1:0] cnt_free;
	logic [COUNT_BITS-1:0] occ_inc;
	logic [COUNT_BITS-1:0] free_inc;
	logic [COUNT_BITS-1:0] free_new;
	logic wb_in_use;

	logic res_load;
	logic [1:0] res_status_d;
	logic [7:0] res_hit_d;
	logic [31:0] res_occ_d;
	logic [31:0] res_free_d;

	assign cfg_ready = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign range_ok = (32'(entry_index) < 32'(MAX_SPOTS));
	assign idx_addr = AW'(entry_index);
	assign out_free = !result_valid || !result_stall;

	always_comb begin
		if (32'(entries_in_use_q) > 32'(MAX_SPOTS)) begin
			n_active = NW'(MAX_SPOTS);
		end else begin
			n_active = NW'(entries_in_use_q);
		end
	end

	assign scan_last = (NW'(scan_q) == (n_active - NW'(1)));
	assign walk_last = (scan_q == AW'(MAX_SPOTS - 1));

	always_comb begin
		scan_ctl = '0;
		if (state_q == ST_SCAN) begin
			scan_ctl.valid = 1'b1;
			scan_ctl.first = (scan_q == '0);
			scan_ctl.last = scan_last;
		end
	end

	assign center_we = accept && (action == ACT_LOAD) && range_ok;

	ncoc_nearest #(
		.MAX_SPOTS(MAX_SPOTS),
		.COORD_BITS(COORD_BITS)
	) u_nearest (
		.clk(clk),
		.arst_n(arst_n),
		.center_we(center_we),
		.center_waddr(idx_addr),
		.center_wx(pos_x[COORD_BITS-1:0]),
		.center_wy(pos_y[COORD_BITS-1:0]),
		.scan_addr(scan_q),
		.scan_ctl(scan_ctl),
		.pos_x(px_q),
		.pos_y(py_q),
		.best_idx(best_idx),
		.done(search_done)
	);

	assign cnt_seen = cnt_rdata[CW-1];
	assign cnt_occ = cnt_rdata[2*COUNT_BITS-1:COUNT_BITS];
	assign cnt_free = cnt_rdata[COUNT_BITS-1:0];
	assign occ_inc = (cnt_occ == {COUNT_BITS{1'b1}}) ? cnt_occ : cnt_occ + COUNT_BITS'(1);
	assign free_inc = (cnt_free == {COUNT_BITS{1'b1}}) ? cnt_free : cnt_free + COUNT_BITS'(1);
	assign wb_in_use = (NW'(wb_addr_s1) < n_active);
	assign free_new = (wb_in_use && !cnt_seen) ? free_inc : cnt_free;

	always_comb begin
		priority case (1'b1)
			(state_q == ST_IDLE): cnt_raddr = idx_addr;
			(state_q == ST_DRAIN): cnt_raddr = best_idx;
			default: cnt_raddr = scan_q;
		endcase
	end

	// The end-of-frame walk writes each entry back in the cycle after reading it.
	always_comb begin
		cnt_we = 1'b0;
		cnt_waddr = scan_q;
		cnt_wdata = '0;
		priority if (state_q == ST_CLEAR) begin
			cnt_we = 1'b1;
		end else if (wb_valid_s1) begin
			cnt_we = 1'b1;
			cnt_waddr = wb_addr_s1;
			cnt_wdata = {1'b0, cnt_occ, free_new};
		end else if ((state_q == ST_CNT) && (action_q == ACT_DETECT)) begin
			cnt_we = 1'b1;
			cnt_waddr = cnt_addr_q;
			cnt_wdata = {1'b1, occ_inc, cnt_free};
		end
	end

	ncoc_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_SPOTS)
	) u_count_ram (
		.clk(clk),
		.we(cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	always_comb begin
		res_load = 1'b0;
		res_status_d = STATUS_OK;
		res_hit_d = '0;
		res_occ_d = '0;
		res_free_d = '0;
		if (accept) begin
			if (((action == ACT_LOAD) || (action == ACT_READ)) && !range_ok) begin
				res_load = 1'b1;
				res_status_d = STATUS_RANGE;
			end else if ((action == ACT_DETECT) && (n_active == '0)) begin
				res_load = 1'b1;
				res_status_d = STATUS_EMPTY;
			end
		end
		if (state_q == ST_CNT) begin
			res_load = 1'b1;
			res_hit_d = 8'(cnt_addr_q);
			res_occ_d = 32'((action_q == ACT_DETECT) ? occ_inc : cnt_occ);
			res_free_d = 32'(cnt_free);
		end
		if (state_q == ST_EOF_END) begin
			res_load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			scan_q <= '0;
			entries_in_use_q <= '0;
			wb_valid_s1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				entries_in_use_q <= entries_in_use;
			end
			wb_valid_s1 <= (state_q == ST_EOF);
			if ((state_q == ST_EMIT) && out_free) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					scan_q <= scan_q + AW'(1);
					if (walk_last) begin
						scan_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						scan_q <= '0;
						unique case (action)
							ACT_LOAD, ACT_READ: state_q <= range_ok ? ST_CNT : ST_EMIT;
							ACT_DETECT: state_q <= (n_active == '0) ? ST_EMIT : ST_SCAN;
							ACT_FRAME: state_q <= ST_EOF;
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + AW'(1);
					if (scan_last) begin
						scan_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (search_done) begin
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					state_q <= ST_EMIT;
				end
				ST_EOF: begin
					scan_q <= scan_q + AW'(1);
					if (walk_last) begin
						scan_q <= '0;
						state_q <= ST_EOF_END;
					end
				end
				ST_EOF_END: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					scan_q <= '0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wb_addr_s1 <= scan_q;
		if (accept) begin
			action_q <= action;
			cnt_addr_q <= idx_addr;
			px_q <= pos_x[COORD_BITS-1:0];
			py_q <= pos_y[COORD_BITS-1:0];
		end else if ((state_q == ST_DRAIN) && search_done) begin
			cnt_addr_q <= best_idx;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_hit_q <= res_hit_d;
			res_occ_q <= res_occ_d;
			res_free_q <= res_free_d;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			status <= res_status_q;
			hit_index <= res_hit_q;
			occupied_count <= res_occ_q;
			free_count <= res_free_q;
		end
	end

endmodule

`default_nettype wire

### design/ncoc_checker.sv
// Port-level checker of the nearest center occupancy counter and its bind.
`default_nettype none

`include "nearest_center_occupancy_counter_unit_macros.svh"

module ncoc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [7:0]  hit_index,
	input logic [31:0] occupied_count,
	input logic [31:0] free_count
);

	import ncoc_pkg::*;

	// A stalled result beat keeps its payload.
	`NCOC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(status) && $stable(hit_index) && $stable(occupied_count) && $stable(free_count), "result beat changed while stalled")

	// Only one item is in the block at a time.
	`NCOC_ASSERT_NEXT(a_one_item, clk, arst_n, item_valid && !item_stall, item_stall, "item accepted while another is in work")

	// A failed item reports no entry and no counts.
	`NCOC_ASSERT_IMPLY(a_fail_zero, clk, arst_n, result_valid && (status != STATUS_OK), (hit_index == 8'd0) && (occupied_count == 32'd0) && (free_count == 32'd0), "failure beat carries nonzero fields")

endmodule

bind nearest_center_occupancy_counter_unit ncoc_checker u_ncoc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.status(status),
	.hit_index(hit_index),
	.occupied_count(occupied_count),
	.free_count(free_count)
);

`default_nettype wire
